// ===== rtl/salru_pkg.sv =====
package salru_pkg;

    localparam int ADDR_BITS = 48;
    localparam int MAX_SETS  = 256;
    localparam int MAX_WAYS  = 8;
    localparam int NLINES    = MAX_SETS * MAX_WAYS;

    localparam int SET_BITS  = $clog2(MAX_SETS);
    localparam int WAY_BITS  = $clog2(MAX_WAYS);
    localparam int LINE_BITS = $clog2(NLINES);
    localparam int STAMP_W   = 32;
    localparam int CNT_W     = 32;

    // largest usable log2 geometry
    localparam logic [3:0] SETS_LOG2_MAX = 4'(SET_BITS);
    localparam logic [2:0] WAYS_LOG2_MAX = 3'(WAY_BITS);

    // operation codes
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_FLUSH = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_LINE_BYTES_LOG2 = 2'd0;
    localparam logic [1:0] CFG_SETS_LOG2       = 2'd1;
    localparam logic [1:0] CFG_WAYS_LOG2       = 2'd2;
    localparam int         CFG_DATA_W          = 8;

    typedef struct packed {
        logic                 valid;
        logic [ADDR_BITS-1:0] tag;
        logic [STAMP_W-1:0]   stamp;
    } entry_t;

    // running result of the way scan
    typedef struct packed {
        logic                hit;
        logic                free;
        logic [WAY_BITS-1:0] hit_way;
        logic [WAY_BITS-1:0] victim;
        logic [STAMP_W-1:0]  best_age;
    } scan_t;

endpackage

// ===== rtl/salru_if.sv =====
interface salru_req_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          opcode;
    logic [salru_pkg::ADDR_BITS-1:0]     phys_addr;

    modport source (output valid, output opcode, output phys_addr, input ready);
    modport sink   (input valid, input opcode, input phys_addr, output ready);
endinterface

interface salru_rsp_if;
    logic                                valid;
    logic                                ready;
    logic                                hit;
    logic [2:0]                          way_used;
    logic [salru_pkg::CNT_W-1:0]         read_total;
    logic [salru_pkg::CNT_W-1:0]         read_miss_total;
    logic [salru_pkg::CNT_W-1:0]         write_total;
    logic [salru_pkg::CNT_W-1:0]         write_miss_total;

    modport source (output valid, output hit, output way_used, output read_total,
                    output read_miss_total, output write_total,
                    output write_miss_total, input ready);
    modport sink   (input valid, input hit, input way_used, input read_total,
                    input read_miss_total, input write_total,
                    input write_miss_total, output ready);
endinterface

interface salru_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          index;
    logic [salru_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/salru_way_cmp.sv =====
// Shared compare unit: folds one way of the set into the running scan.
module salru_way_cmp (
    input  salru_pkg::entry_t                    entry,
    input  logic [salru_pkg::ADDR_BITS-1:0]      tag,
    input  logic [salru_pkg::STAMP_W-1:0]        access_clock,
    input  logic [salru_pkg::WAY_BITS-1:0]       way,
    input  salru_pkg::scan_t                     scan_cur,
    output salru_pkg::scan_t                     scan_nxt
);

    logic [salru_pkg::STAMP_W-1:0] age;

    assign age = access_clock - entry.stamp;

    always_comb
    begin
        scan_nxt = scan_cur;
        if (!scan_cur.hit)
        begin
            if (entry.valid && (entry.tag == tag))
            begin
                scan_nxt.hit     = 1'b1;
                scan_nxt.hit_way = way;
            end
            else if (!scan_cur.free)
            begin
                if (!entry.valid)
                begin
                    scan_nxt.free   = 1'b1;
                    scan_nxt.victim = way;
                end
                else if ((way == '0) || (age > scan_cur.best_age))
                begin
                    scan_nxt.best_age = age;
                    scan_nxt.victim   = way;
                end
            end
        end
    end

endmodule

// ===== rtl/set_assoc_cache_lookup_lru_top.sv =====
// Read or write: the set is scanned way by way (every way on a miss, up to the hitting way
// on a hit), then the line is written; clear goes straight to the result; flush sweeps all lines.
// Each way costs a read of the single tag memory port and a visit to the shared compare.
// Throughput: one transaction at a time; the next is taken from the cycle after the
// result enters the output register, which holds it until the consumer takes it.
// Reset: counters, clock and geometry at once, then a sweep of the whole tag memory.
module set_assoc_cache_lookup_lru_top (
    input  logic          clk,
    input  logic          rst_n,
    salru_req_if.sink     req,
    salru_rsp_if.source   rsp,
    salru_cfg_if.sink     cfg
);

    // Sequencer states
    localparam logic [2:0] ST_CLEAR  = 3'd0;  // sweep the tag memory
    localparam logic [2:0] ST_IDLE   = 3'd1;  // wait for a transaction
    localparam logic [2:0] ST_READ   = 3'd2;  // issue read of the current way
    localparam logic [2:0] ST_CMP    = 3'd3;  // compare the returned way
    localparam logic [2:0] ST_WRITE  = 3'd4;  // update line, clock, counters
    localparam logic [2:0] ST_RESULT = 3'd5;  // load output register

    logic [2:0] state_reg, state_next;

    // Configuration
    logic [2:0] line_log2_reg;
    logic [3:0] sets_log2_reg;
    logic [1:0] ways_log2_reg;

    // Tag memory, one entry per line, addressed {set, way}
    salru_pkg::entry_t mem [salru_pkg::NLINES];
    salru_pkg::entry_t mem_q_reg;
    logic                               mem_we;
    logic [salru_pkg::LINE_BITS-1:0]    mem_waddr;
    salru_pkg::entry_t                  mem_wdata;
    logic [salru_pkg::LINE_BITS-1:0]    mem_raddr;

    logic [salru_pkg::LINE_BITS-1:0] clr_cnt_reg;
    logic                            flush_reply_reg;

    // Per-transaction working registers
    logic [1:0]                      op_reg;
    logic [salru_pkg::SET_BITS-1:0]  set_reg;
    logic [salru_pkg::ADDR_BITS-1:0] tag_reg;
    logic [salru_pkg::WAY_BITS-1:0]  way_reg;
    salru_pkg::scan_t                scan_reg, scan_cmp;

    logic [salru_pkg::STAMP_W-1:0]   clock_reg;
    logic [salru_pkg::CNT_W-1:0]     rd_cnt_reg, rd_miss_reg, wr_cnt_reg, wr_miss_reg;

    logic                            res_hit_reg;
    logic [salru_pkg::WAY_BITS-1:0]  res_way_reg;

    // Output register
    logic                            out_valid_reg;
    logic                            out_hit_reg;
    logic [2:0]                      out_way_reg;
    logic [salru_pkg::CNT_W-1:0]     out_rd_reg, out_rd_miss_reg, out_wr_reg, out_wr_miss_reg;

    // Geometry and address split
    logic [3:0]                      slog;
    logic [2:0]                      wlog;
    logic [salru_pkg::WAY_BITS-1:0]  way_last;
    logic [4:0]                      tag_lsb;
    logic [salru_pkg::ADDR_BITS-1:0] set_shifted;
    logic [salru_pkg::SET_BITS-1:0]  set_mask;
    logic [salru_pkg::SET_BITS-1:0]  req_set;
    logic [salru_pkg::ADDR_BITS-1:0] req_tag;

    logic req_fire, out_free;

    assign slog = (sets_log2_reg > salru_pkg::SETS_LOG2_MAX) ? salru_pkg::SETS_LOG2_MAX
                                                              : sets_log2_reg;
    assign wlog = ({1'b0, ways_log2_reg} > salru_pkg::WAYS_LOG2_MAX)
                  ? salru_pkg::WAYS_LOG2_MAX : {1'b0, ways_log2_reg};
    assign way_last    = ~({salru_pkg::WAY_BITS{1'b1}} << wlog);
    assign tag_lsb     = {2'b00, line_log2_reg} + {1'b0, slog};
    assign set_shifted = req.phys_addr >> line_log2_reg;
    assign set_mask    = ~({salru_pkg::SET_BITS{1'b1}} << slog);
    assign req_set     = set_shifted[salru_pkg::SET_BITS-1:0] & set_mask;
    assign req_tag     = req.phys_addr >> tag_lsb;

    assign req.ready = (state_reg == ST_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign out_free  = !out_valid_reg || rsp.ready;

    // Configuration writes are always taken; indexes past the list are dropped
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_log2_reg <= 3'd6;
            sets_log2_reg <= 4'd6;
            ways_log2_reg <= 2'd1;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                salru_pkg::CFG_LINE_BYTES_LOG2: line_log2_reg <= cfg.data[2:0];
                salru_pkg::CFG_SETS_LOG2:       sets_log2_reg <= cfg.data[3:0];
                salru_pkg::CFG_WAYS_LOG2:       ways_log2_reg <= cfg.data[1:0];
                default:                        ;
            endcase
        end
    end

    // The shared compare unit sees one way per visit to ST_CMP
    salru_way_cmp u_cmp (
        .entry        (mem_q_reg),
        .tag          (tag_reg),
        .access_clock (clock_reg),
        .way          (way_reg),
        .scan_cur     (scan_reg),
        .scan_nxt     (scan_cmp)
    );

    // Memory ports: one write, one registered read
    assign mem_raddr = {set_reg, way_reg};

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = clr_cnt_reg;
        mem_wdata = '0;
        if (state_reg == ST_CLEAR)
        begin
            mem_we = 1'b1;
        end
        else if (state_reg == ST_WRITE)
        begin
            mem_we          = 1'b1;
            mem_waddr       = {set_reg, scan_reg.hit ? scan_reg.hit_way : scan_reg.victim};
            mem_wdata.valid = 1'b1;
            mem_wdata.tag   = tag_reg;
            mem_wdata.stamp = clock_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_q_reg <= mem[mem_raddr];
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == {salru_pkg::LINE_BITS{1'b1}})
                begin
                    state_next = flush_reply_reg ? ST_RESULT : ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    case (req.opcode)
                        salru_pkg::OP_FLUSH: state_next = ST_CLEAR;
                        salru_pkg::OP_CLEAR: state_next = ST_RESULT;
                        default:             state_next = ST_READ;
                    endcase
                end
            end
            ST_READ:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (scan_cmp.hit || (way_reg == way_last))
                begin
                    state_next = ST_WRITE;
                end
                else
                begin
                    state_next = ST_READ;
                end
            end
            ST_WRITE:
            begin
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            clr_cnt_reg     <= '0;
            flush_reply_reg <= 1'b0;
            clock_reg       <= '0;
            rd_cnt_reg      <= '0;
            rd_miss_reg     <= '0;
            wr_cnt_reg      <= '0;
            wr_miss_reg     <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end

            if (req_fire)
            begin
                flush_reply_reg <= (req.opcode == salru_pkg::OP_FLUSH);
                if (req.opcode == salru_pkg::OP_CLEAR)
                begin
                    rd_cnt_reg  <= '0;
                    rd_miss_reg <= '0;
                    wr_cnt_reg  <= '0;
                    wr_miss_reg <= '0;
                end
            end

            // Advance the access clock and the counters once per access
            if (state_reg == ST_WRITE)
            begin
                clock_reg <= clock_reg + 1'b1;
                if (op_reg == salru_pkg::OP_READ)
                begin
                    rd_cnt_reg <= rd_cnt_reg + 1'b1;
                    if (!scan_reg.hit)
                    begin
                        rd_miss_reg <= rd_miss_reg + 1'b1;
                    end
                end
                else
                begin
                    wr_cnt_reg <= wr_cnt_reg + 1'b1;
                    if (!scan_reg.hit)
                    begin
                        wr_miss_reg <= wr_miss_reg + 1'b1;
                    end
                end
            end

            // Hold the result until the consumer takes the transaction
            if ((state_reg == ST_RESULT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Working payload registers
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            op_reg      <= req.opcode;
            set_reg     <= req_set;
            tag_reg     <= req_tag;
            way_reg     <= '0;
            scan_reg    <= '0;
            res_hit_reg <= 1'b0;
            res_way_reg <= '0;
        end
        else if (state_reg == ST_CMP)
        begin
            scan_reg <= scan_cmp;
            way_reg  <= way_reg + 1'b1;
        end
        else if (state_reg == ST_WRITE)
        begin
            res_hit_reg <= scan_reg.hit;
            res_way_reg <= scan_reg.hit ? scan_reg.hit_way : scan_reg.victim;
        end

        if ((state_reg == ST_RESULT) && out_free)
        begin
            out_hit_reg     <= res_hit_reg;
            out_way_reg     <= 3'(res_way_reg);
            out_rd_reg      <= rd_cnt_reg;
            out_rd_miss_reg <= rd_miss_reg;
            out_wr_reg      <= wr_cnt_reg;
            out_wr_miss_reg <= wr_miss_reg;
        end
    end

    assign rsp.valid            = out_valid_reg;
    assign rsp.hit              = out_hit_reg;
    assign rsp.way_used         = out_way_reg;
    assign rsp.read_total       = out_rd_reg;
    assign rsp.read_miss_total  = out_rd_miss_reg;
    assign rsp.write_total      = out_wr_reg;
    assign rsp.write_miss_total = out_wr_miss_reg;

endmodule

// ===== tb/lookup_checker.sv =====
module lookup_checker
    import salru_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    salru_req_if req,
    salru_rsp_if rsp,
    salru_cfg_if cfg,
    output int   fail_count,
    output int   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic             hit;
        logic [2:0]       way_used;
        logic [CNT_W-1:0] read_total;
        logic [CNT_W-1:0] read_miss_total;
        logic [CNT_W-1:0] write_total;
        logic [CNT_W-1:0] write_miss_total;
    } lookup_result_t;

    // tag store image, one entry per line, set-major
    logic [ADDR_BITS-1:0] line_tag   [NLINES];
    logic                 line_valid [NLINES];
    logic [STAMP_W-1:0]   line_stamp [NLINES];
    logic [STAMP_W-1:0]   access_count;
    logic [CNT_W-1:0]     rd_cnt, rd_miss_cnt, wr_cnt, wr_miss_cnt;

    logic [2:0] line_log2;
    logic [3:0] sets_log2;
    logic [1:0] ways_log2;

    lookup_result_t expected_lookups [$];

    function automatic lookup_result_t predict_lookup(input logic [1:0]           op,
                                                      input logic [ADDR_BITS-1:0] addr);
        lookup_result_t       r;
        int unsigned          slog, wlog, set_idx, base, victim;
        logic [ADDR_BITS-1:0] tag;
        logic [STAMP_W-1:0]   age, best_age;
        bit                   found;
        r = '0;
        if (op == OP_FLUSH) begin
            for (int i = 0; i < NLINES; i++) begin
                line_tag[i]   = '0;
                line_valid[i] = 1'b0;
                line_stamp[i] = '0;
            end
        end else if (op == OP_CLEAR) begin
            rd_cnt      = '0;
            rd_miss_cnt = '0;
            wr_cnt      = '0;
            wr_miss_cnt = '0;
        end else begin
            slog     = (sets_log2 > SET_BITS) ? SET_BITS : sets_log2;
            wlog     = (ways_log2 > WAY_BITS) ? WAY_BITS : ways_log2;
            set_idx  = 32'((addr >> line_log2) & ((ADDR_BITS'(1) << slog) - ADDR_BITS'(1)));
            tag      = addr >> (line_log2 + slog);
            base     = set_idx * MAX_WAYS;
            found    = 1'b0;
            victim   = 0;
            best_age = '0;
            for (int w = 0; w < (1 << wlog); w++) begin
                if (!found && line_valid[base + w] && line_tag[base + w] == tag) begin
                    found      = 1'b1;
                    r.way_used = 3'(w);
                end
            end
            if (found) begin
                r.hit = 1'b1;
                line_stamp[base + r.way_used] = access_count;
            end else begin
                // lowest free way first, else the oldest by age modulo 2^32
                for (int w = 0; w < (1 << wlog); w++) begin
                    if (!found) begin
                        if (!line_valid[base + w]) begin
                            victim = w;
                            found  = 1'b1;
                        end else begin
                            age = access_count - line_stamp[base + w];
                            if (w == 0 || age > best_age) begin
                                best_age = age;
                                victim   = w;
                            end
                        end
                    end
                end
                r.way_used                 = 3'(victim);
                line_tag[base + victim]    = tag;
                line_valid[base + victim]  = 1'b1;
                line_stamp[base + victim]  = access_count;
            end
            if (op == OP_READ) begin
                rd_cnt = rd_cnt + 1'b1;
                if (!r.hit)
                    rd_miss_cnt = rd_miss_cnt + 1'b1;
            end else begin
                wr_cnt = wr_cnt + 1'b1;
                if (!r.hit)
                    wr_miss_cnt = wr_miss_cnt + 1'b1;
            end
            access_count = access_count + 1'b1;
        end
        r.read_total       = rd_cnt;
        r.read_miss_total  = rd_miss_cnt;
        r.write_total      = wr_cnt;
        r.write_miss_total = wr_miss_cnt;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [CNT_W-1:0] want,
                                        input logic [CNT_W-1:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin : watch
        lookup_result_t got, want;
        if (!rst_n) begin
            for (int i = 0; i < NLINES; i++) begin
                line_tag[i]   = '0;
                line_valid[i] = 1'b0;
                line_stamp[i] = '0;
            end
            access_count = '0;
            rd_cnt       = '0;
            rd_miss_cnt  = '0;
            wr_cnt       = '0;
            wr_miss_cnt  = '0;
            line_log2    = 3'd6;
            sets_log2    = 4'd6;
            ways_log2    = 2'd1;
            expected_lookups.delete();
            fail_count   = 0;
            pending     <= 0;
        end else begin
            if (cfg.valid && cfg.ready) begin
                case (cfg.index)
                    CFG_LINE_BYTES_LOG2: line_log2 = cfg.data[2:0];
                    CFG_SETS_LOG2:       sets_log2 = cfg.data[3:0];
                    CFG_WAYS_LOG2:       ways_log2 = cfg.data[1:0];
                    default: ;
                endcase
            end
            if (req.valid && req.ready)
                expected_lookups.push_back(predict_lookup(req.opcode, req.phys_addr));
            if (rsp.valid && rsp.ready) begin
                got.hit              = rsp.hit;
                got.way_used         = rsp.way_used;
                got.read_total       = rsp.read_total;
                got.read_miss_total  = rsp.read_miss_total;
                got.write_total      = rsp.write_total;
                got.write_miss_total = rsp.write_miss_total;
                if (expected_lookups.size() == 0) begin
                    $error("result transaction arrived with nothing outstanding");
                    fail_count++;
                end else begin
                    want = expected_lookups.pop_front();
                    check_field("hit", want.hit, got.hit);
                    check_field("way_used", want.way_used, got.way_used);
                    check_field("read_total", want.read_total, got.read_total);
                    check_field("read_miss_total", want.read_miss_total,
                                got.read_miss_total);
                    check_field("write_total", want.write_total, got.write_total);
                    check_field("write_miss_total", want.write_miss_total,
                                got.write_miss_total);
                end
            end
            pending <= expected_lookups.size();
        end
    end

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import salru_pkg::*;

    localparam int ITEMS_PER_PHASE = 170;
    localparam int NUM_PHASES      = 7;

    logic clk = 1'b0;
    logic rst_n;
    int   fail_count;
    int   pending;

    // stimulus-side copy of the geometry, used only to aim addresses at sets
    logic [2:0] cur_line;
    logic [3:0] cur_sets;

    // pool of recently used addresses so that hits and set conflicts recur
    logic [ADDR_BITS-1:0] recent [16];

    bit send_tight;
    bit take_tight;
    int n_reads, n_writes, n_flush, n_clear, n_results;

    salru_req_if req_ch ();
    salru_rsp_if rsp_ch ();
    salru_cfg_if cfg_ch ();

    set_assoc_cache_lookup_lru_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    lookup_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_ch),
        .rsp        (rsp_ch),
        .cfg        (cfg_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [ADDR_BITS-1:0] rand_addr();
        return ADDR_BITS'({$urandom, $urandom});
    endfunction

    // Aim an access: mostly the same line as a recent one (offset bits
    // shuffled), often the same set with a tag from a small family so that
    // the set fills and LRU eviction kicks in, and now and then anywhere.
    function automatic logic [ADDR_BITS-1:0] pick_address();
        logic [ADDR_BITS-1:0] seed_addr, low_mask, tag_part, a;
        int unsigned          split, roll;
        split     = cur_line + ((cur_sets > SETS_LOG2_MAX) ? SETS_LOG2_MAX : cur_sets);
        low_mask  = (ADDR_BITS'(1) << split) - ADDR_BITS'(1);
        seed_addr = recent[$urandom_range(0, 15)];
        roll      = $urandom_range(0, 99);
        if (roll < 55) begin
            a = seed_addr ^ (rand_addr() & ((ADDR_BITS'(1) << cur_line) - ADDR_BITS'(1)));
        end else if (roll < 85) begin
            tag_part = ($urandom_range(0, 3) == 0) ? rand_addr()
                                                   : ADDR_BITS'($urandom_range(0, 11));
            a = (seed_addr & low_mask) | (tag_part << split);
        end else begin
            a = rand_addr();
        end
        if ($urandom_range(0, 3) == 0)
            recent[$urandom_range(0, 15)] = a;
        return a;
    endfunction

    // Keep flushes rare: each one costs a full sweep of the tag memory.
    function automatic logic [1:0] pick_op();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 2)
            return OP_FLUSH;
        if (roll < 5)
            return OP_CLEAR;
        return roll[0] ? OP_WRITE : OP_READ;
    endfunction

    // Offer one request transaction. Valid is lowered only when a gap is
    // drawn, so a back-to-back item keeps it high with no toggle in one step.
    task automatic send_item(input logic [1:0] op, input logic [ADDR_BITS-1:0] addr);
        int gap;
        gap = send_tight ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.opcode    <= op;
        req_ch.phys_addr <= addr;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        case (op)
            OP_READ:  n_reads++;
            OP_WRITE: n_writes++;
            OP_FLUSH: n_flush++;
            default:  n_clear++;
        endcase
    endtask

    // Drop valid and wait until every issued transaction has come back.
    // The outstanding count is registered, hence the first step.
    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Result side: random back-pressure, with tight stretches, and one long
    // hold-off so the output register stays full and the request side stalls.
    initial
    begin : take_results
        int gap;
        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                take_tight = !take_tight;
            if (n_results == 300)
                gap = 400;
            else
                gap = take_tight ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge clk);
            while (!rsp_ch.valid)
                @(posedge clk);
            n_results++;
        end
    end

    initial
    begin : stimulus
        // geometry per phase: minimum, maximum, oversized set count, then mixes
        logic [2:0] line_sel [NUM_PHASES];
        logic [3:0] sets_sel [NUM_PHASES];
        logic [1:0] ways_sel [NUM_PHASES];
        logic [1:0] op;

        line_sel = '{3'd0, 3'd7, 3'd7, 3'd2, 3'd4, 3'd5, 3'd6};
        sets_sel = '{4'd0, 4'd8, 4'd15, 4'd3, 4'd1, 4'd5, 4'd6};
        ways_sel = '{2'd0, 2'd3, 2'd3, 2'd2, 2'd3, 2'd0, 2'd1};

        rst_n            <= 1'b0;
        req_ch.valid     <= 1'b0;
        req_ch.opcode    <= OP_READ;
        req_ch.phys_addr <= '0;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.index     <= CFG_LINE_BYTES_LOG2;
        cfg_ch.data      <= '0;
        cur_line = 3'd6;
        cur_sets = 4'd6;
        foreach (recent[i])
            recent[i] = rand_addr();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed, reset geometry: 64-byte lines, 64 sets, two ways.
        // Set 0 sees tags 0, 1, 2; the hit on tag 0 between the fills must
        // refresh its age so that tag 1 is evicted, not tag 0.
        send_item(OP_READ,  48'h0000_0000_0000);     // cold miss, way 0
        send_item(OP_READ,  48'h0000_0000_0000);     // hit
        send_item(OP_WRITE, 48'hFFFF_FFFF_FFFF);     // all-ones address
        send_item(OP_WRITE, 48'hFFFF_FFFF_FFC0);     // same line, other offset
        send_item(OP_READ,  48'h0000_0000_1000);     // set 0, free way 1 taken
        send_item(OP_READ,  48'h0000_0000_0020);     // hit refreshes tag 0
        send_item(OP_READ,  48'h0000_0000_2000);     // full set, evict tag 1
        send_item(OP_READ,  48'h0000_0000_1000);     // miss again, evict tag 0
        send_item(OP_WRITE, 48'h0000_0000_2000);     // write hit
        send_item(OP_CLEAR, 48'hFFFF_FFFF_FFFF);     // address ignored
        send_item(OP_READ,  48'h0000_0000_0040);     // set 1
        send_item(OP_WRITE, 48'h8000_0000_0000);     // top address bit alone
        send_item(OP_FLUSH, 48'h5555_5555_5555);     // drop every line
        send_item(OP_READ,  48'h0000_0000_2000);     // miss after flush, way 0
        send_item(OP_WRITE, 48'hAAAA_AAAA_AAAA);
        send_item(OP_READ,  48'h5555_5555_5555);
        send_item(OP_WRITE, 48'h0000_0000_0000);
        send_item(OP_CLEAR, 48'h0000_0000_0000);

        // Random phases. Lines stay valid across a geometry change, so each
        // phase starts by looking up what the previous split left behind.
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            wait_idle();
            write_reg(CFG_LINE_BYTES_LOG2, CFG_DATA_W'(line_sel[phase]));
            write_reg(CFG_SETS_LOG2,       CFG_DATA_W'(sets_sel[phase]));
            write_reg(CFG_WAYS_LOG2,       CFG_DATA_W'(ways_sel[phase]));
            cur_line = line_sel[phase];
            cur_sets = sets_sel[phase];
            repeat (ITEMS_PER_PHASE) begin
                if ($urandom_range(0, 49) == 0)
                    send_tight = !send_tight;
                op = pick_op();
                if (op == OP_READ || op == OP_WRITE)
                    send_item(op, pick_address());
                else
                    send_item(op, rand_addr());
            end
        end

        // Drain: everything issued must come back, then a short settle.
        wait_idle();
        repeat (50) @(posedge clk);

        $display("Covered %0d reads, %0d writes, %0d flushes, %0d counter clears",
                 n_reads, n_writes, n_flush, n_clear);
        $display("over %0d geometries plus reset, %0d results compared, one long output stall",
                 NUM_PHASES, n_results);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #(20_000_000);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
